// File: rtl/stt_pkg.sv
// Shared types and codes for the software timer table.
package stt_pkg;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_TICK   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] timeout_ticks;
    logic [15:0] user_tag;
    logic [6:0]  slot_select;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [6:0]  slot_out;
    logic        fired;
    logic [15:0] fired_tag;
  } result_t;

  // One slot of the timer table as held in the memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] deadline;
    logic [15:0] tag;
  } entry_t;

endpackage

// File: rtl/stt_mem.sv
// Timer slot memory: one write port, one read port with registered read data.
module stt_mem #(
  parameter int Depth = 128,
  parameter int AddrW = 7
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  stt_pkg::entry_t      wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output stt_pkg::entry_t      rdata_o
);

  stt_pkg::entry_t mem_q [Depth];
  stt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/stt_ctrl.sv
// Sequencer of the timer table: clearing pass, item decode and slot sweep.
module stt_ctrl #(
  parameter int Slots = 128,
  parameter int IdxW  = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  stt_pkg::item_t         item_i,
  output stt_pkg::result_t       result_o,
  output logic                   done_o,
  output logic                   mem_we_o,
  output logic [IdxW-1:0]        mem_waddr_o,
  output stt_pkg::entry_t        mem_wdata_o,
  output logic                   mem_re_o,
  output logic [IdxW-1:0]        mem_raddr_o,
  input  stt_pkg::entry_t        mem_rdata_i
);

  localparam int CntW = $clog2(Slots + 1);

  stt_pkg::state_e  state_q, state_d;
  logic [IdxW-1:0]  clr_q, clr_d;
  logic [CntW-1:0]  issue_q, issue_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  stt_pkg::action_e op_q, op_d;
  logic [15:0]      tag_q, tag_d;
  logic [31:0]      deadline_q, deadline_d;
  logic [31:0]      tick_q, tick_d;
  stt_pkg::result_t res_q, res_d;
  logic             done_q, done_d;

  logic             create_ok;
  logic             scan_hit;
  logic             scan_end;
  logic [31:0]      sel_wide;
  logic [31:0]      slot_wide;

  assign busy      = (state_q != stt_pkg::ST_IDLE);
  assign create_ok = (item_i.action == stt_pkg::ACT_CREATE) &&
                     (item_i.user_tag != 16'd0) && (item_i.timeout_ticks != 32'd0);
  assign sel_wide  = 32'(item_i.slot_select);
  assign slot_wide = 32'(rd_idx_q);

  // A create looks for a free slot, a tick for a valid slot that is due.
  assign scan_hit = (op_q == stt_pkg::ACT_CREATE) ? !mem_rdata_i.valid :
                    (mem_rdata_i.valid && (tick_q >= mem_rdata_i.deadline));
  assign scan_end = !rd_vld_q && (issue_q == CntW'(Slots));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stt_pkg::ST_CLEAR: begin
        if (clr_q == IdxW'(Slots - 1)) begin
          state_d = stt_pkg::ST_IDLE;
        end
      end
      stt_pkg::ST_IDLE: begin
        if (start && (create_ok || (item_i.action == stt_pkg::ACT_TICK))) begin
          state_d = stt_pkg::ST_SCAN;
        end
      end
      stt_pkg::ST_SCAN: begin
        if ((rd_vld_q && scan_hit) || scan_end) begin
          state_d = stt_pkg::ST_IDLE;
        end
      end
      default: state_d = stt_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    op_d        = op_q;
    tag_d       = tag_q;
    deadline_d  = deadline_q;
    tick_d      = tick_q;
    res_d       = res_q;
    done_d      = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    unique case (state_q)
      stt_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + 1'b1;
      end
      stt_pkg::ST_IDLE: begin
        issue_d = '0;
        if (start) begin
          res_d = '0;
          case (item_i.action)
            stt_pkg::ACT_CREATE: begin
              if (create_ok) begin
                op_d       = stt_pkg::ACT_CREATE;
                tag_d      = item_i.user_tag;
                deadline_d = tick_q + item_i.timeout_ticks;
              end else begin
                res_d.status = stt_pkg::STAT_REJECT;
                done_d       = 1'b1;
              end
            end
            stt_pkg::ACT_DELETE: begin
              mem_we_o    = (sel_wide < 32'(Slots));
              mem_waddr_o = sel_wide[IdxW-1:0];
              done_d      = 1'b1;
            end
            stt_pkg::ACT_TICK: begin
              op_d   = stt_pkg::ACT_TICK;
              tick_d = tick_q + 32'd1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      stt_pkg::ST_SCAN: begin
        // One read issued per cycle; the entry read last cycle is checked now.
        if (issue_q < CntW'(Slots)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = issue_q[IdxW-1:0];
          issue_d     = issue_q + 1'b1;
          rd_vld_d    = 1'b1;
          rd_idx_d    = issue_q[IdxW-1:0];
        end
        if (rd_vld_q && scan_hit) begin
          mem_we_o       = 1'b1;
          mem_waddr_o    = rd_idx_q;
          res_d          = '0;
          res_d.slot_out = slot_wide[6:0];
          done_d         = 1'b1;
          if (op_q == stt_pkg::ACT_CREATE) begin
            mem_wdata_o.valid    = 1'b1;
            mem_wdata_o.deadline = deadline_q;
            mem_wdata_o.tag      = tag_q;
          end else begin
            res_d.fired     = 1'b1;
            res_d.fired_tag = mem_rdata_i.tag;
          end
        end else if (scan_end) begin
          res_d  = '0;
          done_d = 1'b1;
          if (op_q == stt_pkg::ACT_CREATE) begin
            res_d.status = stt_pkg::STAT_FULL;
          end
        end
      end
      default: begin
        clr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= stt_pkg::ST_CLEAR;
      clr_q    <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
      tick_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
      tick_q   <= tick_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    op_q       <= op_d;
    tag_q      <= tag_d;
    deadline_q <= deadline_d;
    res_q      <= res_d;
  end

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

// File: rtl/software_timer_table_top.sv
// Software timer table top level: slot memory, sequencer and checks.
// A delete, a rejected create or an unknown action answers in the cycle after its beat.
// A valid create or a tick sweeps the slots, one memory read a cycle, and answers on a hit
// or after the last slot; the next beat can be taken at the edge that takes the answer.
// After reset a clearing pass over every slot holds busy high; the tick count starts at zero.
// Each result beat shows for one cycle on done_o; the receiver cannot stall it.
module software_timer_table_top #(
  parameter int SLOTS = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  stt_pkg::item_t   item_i,
  output stt_pkg::result_t result_o,
  output logic             done_o
);

  // Width of a slot index; a table of any size in range has at least one bit.
  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  stt_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  stt_pkg::entry_t mem_rdata;

  // The sequencer owns the tick counter and the result register, and does all
  // read-modify-write traffic to the slot memory. Only one sweep runs at a
  // time, and the one write it may make lands before the next sweep reads, so no
  // forwarding is needed.
  stt_ctrl #(
    .Slots (SLOTS),
    .IdxW  (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .result_o    (result_o),
    .done_o      (done_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Each slot holds its valid flag, deadline and tag in one memory word.
  stt_mem #(
    .Depth (SLOTS),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // A result beat only ever follows an accepted item or a sweep in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start) || $past(busy)))
    else $error("result beat without an item in flight");

  // Only a tick that fired reports a tag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.fired) |-> (result_o.fired_tag == 16'd0))
    else $error("tag reported without a fired timer");

  // A failed create carries no slot and fires nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status != stt_pkg::STAT_OK)) |->
      ((result_o.slot_out == 7'd0) && !result_o.fired))
    else $error("failed create carries slot or fire");

  // The block is never ready while a sweep reads the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> busy)
    else $error("memory sweep while idle");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the software timer table: directed, full-table and random beats.
module tb;

  localparam int NUM_SLOTS  = 128;
  localparam int MAX_GAP    = 14;
  // Slowest item is a full sweep of the slots plus the longest sender gap;
  // about 1000 items of that kind fit several times over in this budget.
  localparam int MAX_CYCLES = 1_000_000;
  // Action code 3 has no member in the package enum; the block must answer it with zeros.
  localparam stt_pkg::action_e ACT_UNKNOWN = stt_pkg::action_e'(2'd3);

  logic             clk = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  stt_pkg::item_t   item_i;
  stt_pkg::result_t result_o;
  logic             done_o;

  software_timer_table_top #(
    .SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .result_o(result_o),
    .done_o  (done_o)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the timer table, advanced at every accepted beat.
  logic [31:0] tick_now;
  logic        timer_valid    [NUM_SLOTS];
  logic [31:0] timer_deadline [NUM_SLOTS];
  logic [15:0] timer_tag      [NUM_SLOTS];

  stt_pkg::result_t timer_answers_due[$];
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  bit      no_gaps        = 1'b0;

  // Works out the answer to one item and updates the shadow table as the block should.
  function automatic stt_pkg::result_t predict_timer_answer(stt_pkg::item_t it);
    stt_pkg::result_t r;
    bit               hit;
    r   = '0;
    hit = 1'b0;
    case (it.action)
      stt_pkg::ACT_CREATE: begin
        if (it.user_tag == 16'd0 || it.timeout_ticks == 32'd0) begin
          r.status = stt_pkg::STAT_REJECT;
        end else begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!hit && !timer_valid[i]) begin
              hit               = 1'b1;
              timer_valid[i]    = 1'b1;
              timer_tag[i]      = it.user_tag;
              timer_deadline[i] = tick_now + it.timeout_ticks;
              r.slot_out        = 7'(i);
            end
          end
          if (!hit) r.status = stt_pkg::STAT_FULL;
        end
      end
      stt_pkg::ACT_DELETE: begin
        if (int'(it.slot_select) < NUM_SLOTS) timer_valid[it.slot_select] = 1'b0;
      end
      stt_pkg::ACT_TICK: begin
        tick_now = tick_now + 32'd1;
        // Plain unsigned compare: a deadline that wrapped past 2^32 is due at once.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!hit && timer_valid[i] && tick_now >= timer_deadline[i]) begin
            hit            = 1'b1;
            timer_valid[i] = 1'b0;
            r.slot_out     = 7'(i);
            r.fired        = 1'b1;
            r.fired_tag    = timer_tag[i];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stt_pkg::item_t make_item(stt_pkg::action_e a, logic [31:0] t,
                                               logic [15:0] g, logic [6:0] s);
    stt_pkg::item_t it;
    it.action        = a;
    it.timeout_ticks = t;
    it.user_tag      = g;
    it.slot_select   = s;
    return it;
  endfunction

  // Sends one beat. Entered and left just after a falling edge; start stays high on
  // return, so a back-to-back beat never lowers and raises it in the same step.
  task automatic send_beat(stt_pkg::item_t it);
    int  gap;
    bit  taken;
    gap   = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    taken = 1'b0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  = 1'b1;
    item_i = it;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        taken = 1'b1;
        timer_answers_due.push_back(predict_timer_answer(it));
      end
      @(negedge clk);
    end
  endtask

  task automatic send_create(logic [31:0] t, logic [15:0] g);
    send_beat(make_item(stt_pkg::ACT_CREATE, t, g, 7'($urandom)));
  endtask

  task automatic send_delete(logic [6:0] s);
    send_beat(make_item(stt_pkg::ACT_DELETE, 32'($urandom), 16'($urandom), s));
  endtask

  task automatic send_tick();
    send_beat(make_item(stt_pkg::ACT_TICK, 32'($urandom), 16'($urandom), 7'($urandom)));
  endtask

  // Every result beat is checked against the oldest outstanding prediction.
  always @(posedge clk) begin : check_answers
    stt_pkg::result_t want;
    if (rst_ni && done_o) begin
      if (timer_answers_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with nothing outstanding, actual %h", $time, result_o);
      end else begin
        want = timer_answers_due.pop_front();
        if (result_o.status !== want.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   result_o.status);
        end
        if (result_o.slot_out !== want.slot_out) begin
          mismatch_count++;
          $display("%0t: slot_out expected %0d actual %0d", $time, want.slot_out,
                   result_o.slot_out);
        end
        if (result_o.fired !== want.fired) begin
          mismatch_count++;
          $display("%0t: fired expected %b actual %b", $time, want.fired, result_o.fired);
        end
        if (result_o.fired_tag !== want.fired_tag) begin
          mismatch_count++;
          $display("%0t: fired_tag expected %h actual %h", $time, want.fired_tag,
                   result_o.fired_tag);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("%0t: run exceeded %0d cycles", $time, MAX_CYCLES);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Rejects, field extremes, the unknown action, a wrapped deadline and lowest-slot firing.
  task automatic test_directed_cases();
    send_tick();
    send_create(32'd5, 16'd0);
    send_create(32'd0, 16'd5);
    send_create(32'd0, 16'd0);
    send_create(32'hFFFF_FFFF, 16'hFFFF);
    send_create(32'd1, 16'd1);
    send_tick();
    send_tick();
    send_beat(make_item(ACT_UNKNOWN, 32'hFFFF_FFFF, 16'hFFFF, 7'h7F));
    send_beat(make_item(ACT_UNKNOWN, 32'd0, 16'd0, 7'd0));
    send_delete(7'h7F);
    send_create(32'd3, 16'h1234);
    send_delete(7'd0);
    repeat (4) send_tick();
    send_create(32'd1, 16'hA5A5);
    send_create(32'd1, 16'h5A5A);
    send_tick();
    send_tick();
    send_delete(7'd0);
  endtask

  // Fills every slot, overfills it with creates, refills a freed slot, drains it by deletes.
  task automatic test_full_table();
    int order[NUM_SLOTS];
    int j;
    int k;
    no_gaps = 1'($urandom_range(0, 1));
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_create($urandom_range(1000, 32'h7FFF_FFFF), 16'($urandom_range(1, 16'hFFFF)));
    end
    send_create(32'hFFFF_FFFF, 16'hFFFF);
    send_create(32'd1, 16'd1);
    send_create(32'd0, 16'h00FF);
    send_tick();
    k = $urandom_range(0, NUM_SLOTS - 1);
    send_delete(7'(k));
    send_create(32'd4000, 16'hBEEF);
    send_create(32'd4000, 16'hBEEF);
    for (int i = 0; i < NUM_SLOTS; i++) order[i] = i;
    for (int i = NUM_SLOTS - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      k        = order[i];
      order[i] = order[j];
      order[j] = k;
    end
    for (int i = 0; i < NUM_SLOTS; i++) send_delete(7'(order[i]));
    no_gaps = 1'b0;
  endtask

  // Mostly live timer traffic with short timeouts, with wraps, rejects and noise mixed in.
  task automatic test_random_traffic(int count);
    int          pick;
    logic [31:0] t;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        case ($urandom_range(0, 9))
          0:       t = 32'($urandom);
          1:       t = 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
          default: t = $urandom_range(1, 30);
        endcase
        if (t == 32'd0) t = 32'd1;
        send_create(t, 16'($urandom_range(1, 16'hFFFF)));
      end else if (pick < 55) begin
        send_delete(($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 15)) : 7'($urandom));
      end else if (pick < 92) begin
        send_tick();
      end else if (pick < 96) begin
        if ($urandom_range(0, 1) == 0) send_create(32'd0, 16'($urandom));
        else send_create(32'($urandom), 16'd0);
      end else begin
        send_beat(make_item(ACT_UNKNOWN, 32'($urandom), 16'($urandom), 7'($urandom)));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    item_i   = '0;
    tick_now = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      timer_valid[i]    = 1'b0;
      timer_deadline[i] = '0;
      timer_tag[i]      = '0;
    end
    repeat (5) @(negedge clk);
    rst_ni = 1'b1;

    test_directed_cases();
    test_full_table();
    test_random_traffic(720);

    start = 1'b0;
    while (timer_answers_due.size() != 0) @(posedge clk);
    // Let any stray beat from a sweep in flight show up before the verdict.
    repeat (NUM_SLOTS + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: software_timer_table_top.f
rtl/stt_pkg.sv
rtl/stt_mem.sv
rtl/stt_ctrl.sv
rtl/software_timer_table_top.sv
tb/sv/tb.sv
